FILE: sv/gte_pkg.sv
// Shared types and codes of the graph traversal engine.
`default_nettype none

package gte_pkg;

  localparam int unsigned IdW   = 7;
  localparam int unsigned DistW = 6;

  typedef logic [IdW-1:0]   node_t;
  typedef logic [DistW-1:0] dist_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DFS    = 2'd1,
    MODE_BFS    = 2'd2,
    MODE_REPORT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_VISIT   = 2'd2,
    KIND_DIST    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e kind;
    node_t node;
    dist_t distance;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_RD_B,
    ST_ADD_WR_B,
    ST_ADD_RES,
    ST_FLUSH,
    ST_D_SCAN,
    ST_D_START,
    ST_D_TOP,
    ST_D_TOP2,
    ST_D_ADV,
    ST_D_PUSH,
    ST_B_INIT,
    ST_B_DEQ,
    ST_B_DEQ2,
    ST_B_VIS,
    ST_B_EDGE,
    ST_B_EDGE2,
    ST_R_RD,
    ST_R_PUSH
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD_RD_A,
    OP_ADD_WR_A,
    OP_ADD_RD_B,
    OP_ADD_WR_B,
    OP_ADD_RES,
    OP_FLUSH,
    OP_D_SCAN,
    OP_D_NEXT,
    OP_D_START,
    OP_D_TOP,
    OP_D_POP,
    OP_D_TOP2,
    OP_D_ADV,
    OP_D_PUSH,
    OP_B_INIT,
    OP_B_DEQ,
    OP_B_DEQ2,
    OP_B_VIS,
    OP_B_EDGE,
    OP_B_EDGE2,
    OP_R_RD,
    OP_R_PUSH
  } op_e;

  typedef struct packed {
    logic add_ok;
    logic can_emit;
    logic flush_ok;
    logic scan_done;
    logic seen_s;
    logic sp_zero;
    logic live_top;
    logic push_ok;
    logic q_empty;
    logic nonempty_t;
    logic e_is_tail;
    logic pend_vld;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/gte_ifs.sv
// Handshake channel interfaces for the input and result beats.
`default_nettype none

interface gte_in_if import gte_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  node_t      node_a;
  node_t      node_b;

  modport source (output valid, mode, node_a, node_b, input ready);
  modport sink   (input valid, mode, node_a, node_b, output ready);
endinterface

interface gte_out_if import gte_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  node_t      node;
  dist_t      distance;
  logic       last;

  modport source (output valid, kind, node, distance, last, input ready);
  modport sink   (input valid, kind, node, distance, last, output ready);
endinterface

`default_nettype wire

FILE: sv/gte_ctrl.sv
// Sequencer of the graph traversal engine: states, commands and handshake.
`default_nettype none

module gte_ctrl import gte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_mode_i,
  input  sts_t       sts_i,
  output logic       in_ready_o,
  output op_e        op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_e'(in_mode_i))
            MODE_ADD: state_d = ST_ADD_RD_A;
            MODE_DFS: state_d = ST_D_SCAN;
            MODE_BFS: state_d = ST_B_INIT;
            default:  state_d = ST_R_RD;
          endcase
        end
      end
      ST_ADD_RD_A: state_d = sts_i.add_ok ? ST_ADD_WR_A : ST_ADD_RES;
      ST_ADD_WR_A: state_d = ST_ADD_RD_B;
      ST_ADD_RD_B: state_d = ST_ADD_WR_B;
      ST_ADD_WR_B: state_d = ST_ADD_RES;
      ST_ADD_RES:  if (sts_i.can_emit) state_d = ST_FLUSH;
      ST_FLUSH:    if (sts_i.flush_ok) state_d = ST_IDLE;
      ST_D_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_FLUSH;
        end else if (!sts_i.seen_s) begin
          state_d = ST_D_START;
        end
      end
      ST_D_START:  if (sts_i.can_emit) state_d = ST_D_TOP;
      ST_D_TOP:    state_d = sts_i.sp_zero ? ST_D_SCAN : ST_D_TOP2;
      ST_D_TOP2:   state_d = sts_i.live_top ? ST_D_ADV : ST_D_TOP;
      ST_D_ADV:    state_d = sts_i.push_ok ? ST_D_PUSH : ST_D_TOP;
      ST_D_PUSH:   if (sts_i.can_emit) state_d = ST_D_TOP;
      ST_B_INIT:   state_d = ST_B_DEQ;
      ST_B_DEQ:    state_d = sts_i.q_empty ? ST_FLUSH : ST_B_DEQ2;
      ST_B_DEQ2:   state_d = ST_B_VIS;
      ST_B_VIS: begin
        if (sts_i.can_emit) begin
          state_d = sts_i.nonempty_t ? ST_B_EDGE : ST_B_DEQ;
        end
      end
      ST_B_EDGE:   state_d = ST_B_EDGE2;
      ST_B_EDGE2:  state_d = sts_i.e_is_tail ? ST_B_DEQ : ST_B_EDGE;
      ST_R_RD:     state_d = sts_i.scan_done ? ST_FLUSH : ST_R_PUSH;
      ST_R_PUSH:   if (sts_i.can_emit) state_d = ST_R_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      ST_ADD_RD_A: if (sts_i.add_ok) op_o = OP_ADD_RD_A;
      ST_ADD_WR_A: op_o = OP_ADD_WR_A;
      ST_ADD_RD_B: op_o = OP_ADD_RD_B;
      ST_ADD_WR_B: op_o = OP_ADD_WR_B;
      ST_ADD_RES:  if (sts_i.can_emit) op_o = OP_ADD_RES;
      ST_FLUSH:    if (sts_i.flush_ok) op_o = OP_FLUSH;
      ST_D_SCAN: begin
        if (!sts_i.scan_done) op_o = sts_i.seen_s ? OP_D_NEXT : OP_D_SCAN;
      end
      ST_D_START:  if (sts_i.can_emit) op_o = OP_D_START;
      ST_D_TOP:    op_o = sts_i.sp_zero ? OP_D_NEXT : OP_D_TOP;
      ST_D_TOP2:   op_o = sts_i.live_top ? OP_D_TOP2 : OP_D_POP;
      ST_D_ADV:    op_o = OP_D_ADV;
      ST_D_PUSH:   if (sts_i.can_emit) op_o = OP_D_PUSH;
      ST_B_INIT:   op_o = OP_B_INIT;
      ST_B_DEQ:    if (!sts_i.q_empty) op_o = OP_B_DEQ;
      ST_B_DEQ2:   op_o = OP_B_DEQ2;
      ST_B_VIS:    if (sts_i.can_emit) op_o = OP_B_VIS;
      ST_B_EDGE:   op_o = OP_B_EDGE;
      ST_B_EDGE2:  op_o = OP_B_EDGE2;
      ST_R_RD:     if (!sts_i.scan_done) op_o = OP_R_RD;
      ST_R_PUSH:   if (sts_i.can_emit) op_o = OP_R_PUSH;
      default:     op_o = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/gte_dp.sv
// Datapath: adjacency store, work stack or queue, distances and result staging.
`default_nettype none

module gte_dp import gte_pkg::*; #(
  parameter int unsigned NODES       = 64,
  parameter int unsigned ENTRY_SLOTS = 512
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  op_e   op_i,
  input  node_t in_a_i,
  input  node_t in_b_i,
  input  logic  cfg_we_i,
  input  node_t cfg_wdata_i,
  input  logic  out_ready_i,
  output sts_t  sts_o,
  output logic  out_valid_o,
  output res_t  out_res_o,
  output logic  out_last_o
);

  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned EW = $clog2(ENTRY_SLOTS);
  localparam int unsigned UW = $clog2(ENTRY_SLOTS + 1);
  localparam int unsigned SW = $clog2(NODES + 1);

  typedef logic [NW-1:0] nidx_t;
  typedef logic [EW-1:0] eptr_t;
  typedef logic [SW-1:0] lvl_t;

  // memories
  node_t nbr_mem   [ENTRY_SLOTS];
  eptr_t next_mem  [ENTRY_SLOTS];
  eptr_t head_mem  [NODES];
  eptr_t tail_mem  [NODES];
  dist_t hop_mem   [NODES];
  node_t wnode_mem [NODES];
  eptr_t wcur_mem  [NODES];

  node_t nbr_rd, wnode_rd;
  eptr_t next_rd, head_rd, tail_rd, wcur_rd;
  dist_t hop_rd;
  logic  hopv_rd;

  // control state
  node_t lim_q, a_q, b_q, idx_q, w_q;
  logic  ok_q;
  logic [UW-1:0] used_q;
  lvl_t  sp_q, qh_q, qt_q;
  dist_t dcur_q;
  eptr_t e_q, tl_q;
  logic [NODES-1:0] nonempty_q, seen_q, hopv_q, live_q;

  res_t  pend_q, out_q;
  logic  pend_vld_q, out_vld_q, out_last_q;

  // index arithmetic
  node_t a_m1, b_m1, idx_m1, nbr_m1, wn_m1, w_m1;
  nidx_t a_ix, b_ix, idx_ix, nbr_ix, wn_ix, w_ix, top_ix, sp_ix, qh_ix, qt_ix;
  lvl_t  sp_m1;
  eptr_t used_ix;

  assign a_m1    = a_q - node_t'(1);
  assign b_m1    = b_q - node_t'(1);
  assign idx_m1  = idx_q - node_t'(1);
  assign nbr_m1  = nbr_rd - node_t'(1);
  assign wn_m1   = wnode_rd - node_t'(1);
  assign w_m1    = w_q - node_t'(1);
  assign sp_m1   = sp_q - lvl_t'(1);
  assign a_ix    = a_m1[NW-1:0];
  assign b_ix    = b_m1[NW-1:0];
  assign idx_ix  = idx_m1[NW-1:0];
  assign nbr_ix  = nbr_m1[NW-1:0];
  assign wn_ix   = wn_m1[NW-1:0];
  assign w_ix    = w_m1[NW-1:0];
  assign top_ix  = sp_m1[NW-1:0];
  assign sp_ix   = sp_q[NW-1:0];
  assign qh_ix   = qh_q[NW-1:0];
  assign qt_ix   = qt_q[NW-1:0];
  assign used_ix = used_q[EW-1:0];

  logic  load_ok, dfs_add, bfs_add, cur_tail;
  dist_t hop_val;

  assign load_ok = (in_a_i != '0) && (in_a_i <= node_t'(NODES)) &&
                   (in_b_i != '0) && (in_b_i <= node_t'(NODES)) &&
                   ({1'b0, used_q} + (UW+1)'(2) <= (UW+1)'(ENTRY_SLOTS));
  assign dfs_add  = !seen_q[nbr_ix] && (sp_q < lvl_t'(NODES));
  assign bfs_add  = !seen_q[nbr_ix] && (qt_q < lvl_t'(NODES));
  assign cur_tail = (wcur_rd == tail_rd);
  assign hop_val  = hopv_rd ? hop_rd : '0;

  logic can_emit, flush_ok;
  assign can_emit = !pend_vld_q || !out_vld_q || out_ready_i;
  assign flush_ok = !out_vld_q || out_ready_i;

  always_comb begin
    sts_o.add_ok     = ok_q;
    sts_o.can_emit   = can_emit;
    sts_o.flush_ok   = flush_ok;
    sts_o.scan_done  = idx_q > lim_q;
    sts_o.seen_s     = seen_q[idx_ix];
    sts_o.sp_zero    = (sp_q == '0);
    sts_o.live_top   = live_q[top_ix];
    sts_o.push_ok    = dfs_add;
    sts_o.q_empty    = (qh_q == qt_q);
    sts_o.nonempty_t = nonempty_q[w_ix];
    sts_o.e_is_tail  = (e_q == tl_q);
    sts_o.pend_vld   = pend_vld_q;
  end

  // memory port control
  logic  nbr_we, nbr_re, next_we, next_re, head_we, head_re, tail_we, tail_re;
  logic  hop_we, hop_re, wnode_we, wnode_re, wcur_we, wcur_re;
  eptr_t nbr_wa, nbr_ra, next_wa, next_ra, next_wd, head_wd, tail_wd, wcur_wd;
  nidx_t head_wa, head_ra, tail_wa, tail_ra, hop_wa, hop_ra;
  nidx_t wnode_wa, wnode_ra, wcur_wa, wcur_ra;
  node_t nbr_wd, wnode_wd;
  dist_t hop_wd;
  logic  app_en;
  nidx_t app_u;
  node_t app_w;

  always_comb begin
    nbr_we = 1'b0; nbr_re = 1'b0; next_we = 1'b0; next_re = 1'b0;
    head_we = 1'b0; head_re = 1'b0; tail_we = 1'b0; tail_re = 1'b0;
    hop_we = 1'b0; hop_re = 1'b0; wnode_we = 1'b0; wnode_re = 1'b0;
    wcur_we = 1'b0; wcur_re = 1'b0;
    nbr_wa = '0; nbr_ra = '0; next_wa = '0; next_ra = '0; next_wd = '0;
    head_wa = '0; head_ra = '0; head_wd = '0;
    tail_wa = '0; tail_ra = '0; tail_wd = '0;
    hop_wa = '0; hop_ra = '0; hop_wd = '0;
    wnode_wa = '0; wnode_ra = '0; wnode_wd = '0;
    wcur_wa = '0; wcur_ra = '0; wcur_wd = '0;
    nbr_wd = '0;
    app_en = 1'b0; app_u = '0; app_w = '0;
    case (op_i)
      OP_ADD_RD_A: begin tail_re = 1'b1; tail_ra = a_ix; end
      OP_ADD_RD_B: begin tail_re = 1'b1; tail_ra = b_ix; end
      OP_ADD_WR_A: begin app_en = 1'b1; app_u = a_ix; app_w = b_q; end
      OP_ADD_WR_B: begin app_en = 1'b1; app_u = b_ix; app_w = a_q; end
      OP_D_SCAN:   begin head_re = 1'b1; head_ra = idx_ix; end
      OP_D_START: begin
        wnode_we = 1'b1; wnode_wa = sp_ix; wnode_wd = idx_q;
        wcur_we  = 1'b1; wcur_wa  = sp_ix; wcur_wd  = head_rd;
      end
      OP_D_TOP: begin
        wnode_re = 1'b1; wnode_ra = top_ix;
        wcur_re  = 1'b1; wcur_ra  = top_ix;
      end
      OP_D_TOP2: begin
        tail_re = 1'b1; tail_ra = wn_ix;
        nbr_re  = 1'b1; nbr_ra  = wcur_rd;
        next_re = 1'b1; next_ra = wcur_rd;
      end
      OP_D_ADV: begin
        if (!cur_tail) begin
          wcur_we = 1'b1; wcur_wa = top_ix; wcur_wd = next_rd;
        end
        head_re = 1'b1; head_ra = nbr_ix;
      end
      OP_D_PUSH: begin
        wnode_we = 1'b1; wnode_wa = sp_ix; wnode_wd = w_q;
        wcur_we  = 1'b1; wcur_wa  = sp_ix; wcur_wd  = head_rd;
      end
      OP_B_INIT: begin
        hop_we   = 1'b1; hop_wa   = '0; hop_wd = '0;
        wnode_we = 1'b1; wnode_wa = '0; wnode_wd = node_t'(1);
      end
      OP_B_DEQ: begin wnode_re = 1'b1; wnode_ra = qh_ix; end
      OP_B_DEQ2: begin
        hop_re  = 1'b1; hop_ra  = wn_ix;
        head_re = 1'b1; head_ra = wn_ix;
        tail_re = 1'b1; tail_ra = wn_ix;
      end
      OP_B_EDGE: begin
        nbr_re  = 1'b1; nbr_ra  = e_q;
        next_re = 1'b1; next_ra = e_q;
      end
      OP_B_EDGE2: begin
        if (bfs_add) begin
          hop_we   = 1'b1; hop_wa   = nbr_ix; hop_wd   = dcur_q + dist_t'(1);
          wnode_we = 1'b1; wnode_wa = qt_ix;  wnode_wd = nbr_rd;
        end
      end
      OP_R_RD: begin hop_re = 1'b1; hop_ra = idx_ix; end
      default: ;
    endcase
    // append to the tail of a list
    if (app_en) begin
      nbr_we = 1'b1; nbr_wa = used_ix; nbr_wd = app_w;
      if (nonempty_q[app_u]) begin
        next_we = 1'b1; next_wa = tail_rd; next_wd = used_ix;
      end else begin
        head_we = 1'b1; head_wa = app_u; head_wd = used_ix;
      end
      tail_we = 1'b1; tail_wa = app_u; tail_wd = used_ix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    if (nbr_re) nbr_rd <= nbr_mem[nbr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (tail_re) tail_rd <= tail_mem[tail_ra];
  end

  // unwritten distances read as zero through the valid flags
  always_ff @(posedge clk_i) begin
    if (hop_we) hop_mem[hop_wa] <= hop_wd;
    if (hop_re) begin
      hop_rd  <= hop_mem[hop_ra];
      hopv_rd <= hopv_q[hop_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wnode_we) wnode_mem[wnode_wa] <= wnode_wd;
    if (wnode_re) wnode_rd <= wnode_mem[wnode_ra];
  end

  always_ff @(posedge clk_i) begin
    if (wcur_we) wcur_mem[wcur_wa] <= wcur_wd;
    if (wcur_re) wcur_rd <= wcur_mem[wcur_ra];
  end

  // sequencing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q      <= node_t'(NODES);
      a_q        <= '0;
      b_q        <= '0;
      ok_q       <= 1'b0;
      used_q     <= '0;
      idx_q      <= '0;
      sp_q       <= '0;
      qh_q       <= '0;
      qt_q       <= '0;
      w_q        <= '0;
      dcur_q     <= '0;
      e_q        <= '0;
      tl_q       <= '0;
      nonempty_q <= '0;
      seen_q     <= '0;
      hopv_q     <= '0;
      live_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) begin
          lim_q <= node_t'(1);
        end else if (cfg_wdata_i > node_t'(NODES)) begin
          lim_q <= node_t'(NODES);
        end else begin
          lim_q <= cfg_wdata_i;
        end
      end
      case (op_i)
        OP_LOAD: begin
          a_q    <= in_a_i;
          b_q    <= in_b_i;
          ok_q   <= load_ok;
          idx_q  <= node_t'(1);
          sp_q   <= '0;
          seen_q <= '0;
        end
        OP_ADD_WR_A, OP_ADD_WR_B: begin
          nonempty_q[app_u] <= 1'b1;
          used_q            <= used_q + UW'(1);
        end
        OP_D_NEXT, OP_R_PUSH: idx_q <= idx_q + node_t'(1);
        OP_D_START: begin
          seen_q[idx_ix] <= 1'b1;
          live_q[sp_ix]  <= nonempty_q[idx_ix];
          sp_q           <= sp_q + lvl_t'(1);
        end
        OP_D_POP: sp_q <= sp_m1;
        OP_D_ADV: begin
          if (cur_tail) live_q[top_ix] <= 1'b0;
          w_q <= nbr_rd;
        end
        OP_D_PUSH: begin
          seen_q[w_ix] <= 1'b1;
          live_q[sp_ix] <= nonempty_q[w_ix];
          sp_q          <= sp_q + lvl_t'(1);
        end
        OP_B_INIT: begin
          seen_q[0] <= 1'b1;
          hopv_q[0] <= 1'b1;
          qh_q      <= '0;
          qt_q      <= lvl_t'(1);
        end
        OP_B_DEQ2: begin
          w_q  <= wnode_rd;
          qh_q <= qh_q + lvl_t'(1);
        end
        OP_B_VIS: begin
          dcur_q <= hop_val;
          e_q    <= head_rd;
          tl_q   <= tail_rd;
        end
        OP_B_EDGE2: begin
          if (bfs_add) begin
            seen_q[nbr_ix] <= 1'b1;
            hopv_q[nbr_ix] <= 1'b1;
            qt_q           <= qt_q + lvl_t'(1);
          end
          e_q <= next_rd;
        end
        default: ;
      endcase
    end
  end

  // result staging: one held back so that the final beat can carry last
  logic push_en, flush_en;
  res_t push_res;

  always_comb begin
    push_en  = 1'b0;
    flush_en = 1'b0;
    push_res = '{kind: KIND_STORED, node: '0, distance: '0};
    case (op_i)
      OP_ADD_RES: begin
        push_en       = 1'b1;
        push_res.kind = ok_q ? KIND_STORED : KIND_DROPPED;
      end
      OP_D_START: begin
        push_en  = 1'b1;
        push_res = '{kind: KIND_VISIT, node: idx_q, distance: '0};
      end
      OP_D_PUSH: begin
        push_en  = 1'b1;
        push_res = '{kind: KIND_VISIT, node: w_q, distance: '0};
      end
      OP_B_VIS: begin
        push_en  = 1'b1;
        push_res = '{kind: KIND_VISIT, node: w_q, distance: hop_val};
      end
      OP_R_PUSH: begin
        push_en  = 1'b1;
        push_res = '{kind: KIND_DIST, node: idx_q, distance: hop_val};
      end
      OP_FLUSH: flush_en = 1'b1;
      default: ;
    endcase
  end

  logic out_load;
  assign out_load = (push_en && pend_vld_q) || flush_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (push_en) begin
        pend_vld_q <= 1'b1;
      end else if (flush_en) begin
        pend_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) pend_q <= push_res;
    if (out_load) begin
      out_q      <= pend_q;
      out_last_q <= flush_en;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: sv/graph_traversal_engine.sv
// Graph traversal engine top level: adjacency-list store with DFS, BFS and distance report.
// Edge add: result staged in ADD_RES and sent in FLUSH; a dropped edge skips the list writes.
// DFS and BFS walk nodes and adjacency entries one at a time, both paced by the single
// read port of each list memory.
// Distance report: one node at a time. One item at a time; input ready only when idle.
// Reset clears lists, marks, distances and the node count (to NODES); no clearing pass.
`default_nettype none

module graph_traversal_engine import gte_pkg::*; #(
  parameter int unsigned NODES       = 64,
  parameter int unsigned ENTRY_SLOTS = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gte_in_if.sink            in_i,
  gte_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  logic [IdW-1:0]    cfg_wdata_i
);

  // Commands flow from the sequencer; status comes back from the datapath.
  op_e  op;
  sts_t sts;
  res_t out_res;
  logic out_last;
  logic out_valid;
  logic in_ready;

  gte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .op_o       (op)
  );

  // Datapath holds the lists, the DFS stack / BFS queue (shared memory),
  // the distance store and a one-deep hold-back so the final beat is tagged.
  gte_dp #(
    .NODES       (NODES),
    .ENTRY_SLOTS (ENTRY_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_a_i      (in_i.node_a),
    .in_b_i      (in_i.node_b),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_o.ready),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_res_o   (out_res),
    .out_last_o  (out_last)
  );

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid;
  assign out_o.kind     = out_res.kind;
  assign out_o.node     = out_res.node;
  assign out_o.distance = out_res.distance;
  assign out_o.last     = out_last;

`ifndef SYNTHESIS
  // nothing may be held back once the engine is ready for a new item
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !sts.pend_vld)
    else $error("held-back result while idle");

  // an accepted item keeps the engine busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // edge results are single, final beats with node zero
  a_edge_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && (out_res.kind == KIND_STORED || out_res.kind == KIND_DROPPED))
      |-> (out_res.node == '0) && out_last)
    else $error("malformed edge result");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_ifs.sv
// Testbench constants: node and entry-store limits matching the block defaults.
package tb_gte_consts;
  localparam int unsigned MaxNodes   = 64;
  localparam int unsigned MaxEntries = 512;
endpackage

FILE: tb/tb_checker.sv
// Checker: watches both channels, predicts results from a graph model and compares.
module tb_checker import gte_pkg::*; import tb_gte_consts::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  in_mode_i,
  input  node_t       in_node_a_i,
  input  node_t       in_node_b_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  out_kind_i,
  input  node_t       out_node_i,
  input  dist_t       out_distance_i,
  input  logic        out_last_i,
  input  logic        cfg_we_i,
  input  node_t       cfg_wdata_i,
  output int          fails_o,
  output int          pending_o
);
  typedef struct packed {
    kind_e kind;
    node_t node;
    dist_t distance;
    logic  last;
  } beat_t;

  beat_t   expected_beats[$];
  int      adj[MaxNodes][$];
  int      entries_used;
  bit      seen[MaxNodes];
  dist_t   hops[MaxNodes];
  int      count_reg;

  function automatic int scan_count();
    if (count_reg < 1) return 1;
    if (count_reg > MaxNodes) return MaxNodes;
    return count_reg;
  endfunction

  function automatic void add_beat(kind_e k, int n, int d);
    beat_t b;
    b.kind = k; b.node = node_t'(n); b.distance = dist_t'(d); b.last = 1'b0;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic void mark_last();
    expected_beats[expected_beats.size()-1].last = 1'b1;
  endfunction

  // Iterative DFS: stack of (node, cursor index into its list).
  function automatic void walk_depth();
    int stk_n[$];
    int stk_c[$];
    int u, w, s;
    for (int i = 0; i < MaxNodes; i++) seen[i] = 0;
    for (s = 1; s <= scan_count(); s++) begin
      if (seen[s-1]) continue;
      add_beat(KIND_VISIT, s, 0);
      seen[s-1] = 1;
      stk_n.insert(stk_n.size(), s); stk_c.insert(stk_c.size(), 0);
      while (stk_n.size() > 0) begin
        u = stk_n[$];
        if (stk_c[$] >= adj[u-1].size()) begin
          void'(stk_n.pop_back()); void'(stk_c.pop_back());
          continue;
        end
        w = adj[u-1][stk_c[$]];
        stk_c[stk_c.size()-1]++;
        if (!seen[w-1] && stk_n.size() < MaxNodes) begin
          add_beat(KIND_VISIT, w, 0);
          seen[w-1] = 1;
          stk_n.insert(stk_n.size(), w); stk_c.insert(stk_c.size(), 0);
        end
      end
    end
    mark_last();
  endfunction

  function automatic void walk_breadth();
    int q[$];
    int qt, t, w;
    for (int i = 0; i < MaxNodes; i++) seen[i] = 0;
    q.insert(0, 1); qt = 1;
    seen[0] = 1; hops[0] = '0;
    while (q.size() > 0) begin
      t = q.pop_front();
      add_beat(KIND_VISIT, t, hops[t-1]);
      for (int j = 0; j < adj[t-1].size(); j++) begin
        w = adj[t-1][j];
        if (!seen[w-1] && qt < MaxNodes) begin
          seen[w-1] = 1;
          hops[w-1] = hops[t-1] + 1'b1;
          q.insert(q.size(), w); qt++;
        end
      end
    end
    mark_last();
  endfunction

  function automatic void predict(mode_e m, int a, int b);
    case (m)
      MODE_ADD: begin
        if (a >= 1 && a <= MaxNodes && b >= 1 && b <= MaxNodes &&
            entries_used + 2 <= MaxEntries) begin
          adj[a-1].insert(adj[a-1].size(), b);
          adj[b-1].insert(adj[b-1].size(), a);
          entries_used += 2;
          add_beat(KIND_STORED, 0, 0);
        end else begin
          add_beat(KIND_DROPPED, 0, 0);
        end
        mark_last();
      end
      MODE_DFS: walk_depth();
      MODE_BFS: walk_breadth();
      default: begin
        for (int i = 1; i <= scan_count(); i++) add_beat(KIND_DIST, i, hops[i-1]);
        mark_last();
      end
    endcase
  endfunction

  assign pending_o = expected_beats.size();

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t e;
    if (!rst_ni) begin
      fails_o <= 0;
      entries_used = 0;
      count_reg = MaxNodes;
      for (int i = 0; i < MaxNodes; i++) begin
        adj[i].delete(); hops[i] = '0; seen[i] = 0;
      end
      expected_beats.delete();
    end else begin
      if (cfg_we_i) count_reg = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat kind=%0d node=%0d", out_kind_i, out_node_i);
          fails_o <= fails_o + 1;
        end else begin
          e = expected_beats.pop_front();
          if (out_kind_i !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, out_kind_i);
            fails_o <= fails_o + 1;
          end else if (out_node_i !== e.node) begin
            $error("node: expected %0d actual %0d", e.node, out_node_i);
            fails_o <= fails_o + 1;
          end else if (out_distance_i !== e.distance) begin
            $error("distance: expected %0d actual %0d", e.distance, out_distance_i);
            fails_o <= fails_o + 1;
          end else if (out_last_i !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, out_last_i);
            fails_o <= fails_o + 1;
          end
        end
      end
      // input prediction after the output check; the block serves one item at a time
      if (in_valid_i && in_ready_i)
        predict(mode_e'(in_mode_i), in_node_a_i, in_node_b_i);
    end
  end
endmodule

FILE: tb/tb_top.sv
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the traversal engine.
module tb_top;
  import gte_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_we;
  node_t cfg_wdata;
  int    fails;
  int    pending;
  int    idle_cycles;
  bit    calm;        // no idling in the final stretch
  bit    hold_long;   // sink holds off for a long stretch

  gte_in_if  in_ch ();
  gte_out_if out_ch ();

  graph_traversal_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  tb_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch.valid),
    .in_ready_i     (in_ch.ready),
    .in_mode_i      (in_ch.mode),
    .in_node_a_i    (in_ch.node_a),
    .in_node_b_i    (in_ch.node_b),
    .out_valid_i    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .out_kind_i     (out_ch.kind),
    .out_node_i     (out_ch.node),
    .out_distance_i (out_ch.distance),
    .out_last_i     (out_ch.last),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fails_o        (fails),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Send one beat, holding valid until accepted at a rising edge.
  // Driven at the falling edge, so blocking updates cannot race the sampling edge.
  task automatic send_beat(mode_e m, int a, int b);
    in_ch.valid  = 1'b1;
    in_ch.mode   = m;
    in_ch.node_a = node_t'(a);
    in_ch.node_b = node_t'(b);
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  // Random gap before some beats.
  task automatic maybe_gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Register writes only with nothing outstanding, plus a margin for a busy block.
  task automatic write_count(int v);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= node_t'(v);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_edge_rand(int hi);
    maybe_gap();
    send_beat(MODE_ADD, $urandom_range(1, hi), $urandom_range(1, hi));
  endtask

  // Sink side: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_long = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no beat accepted on either side and no register write.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_ADD;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    calm         = 1'b0;
    hold_long    = 1'b0;
    rst_ni       = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: report of fresh distances, searches on an empty graph.
    send_beat(MODE_REPORT, 0, 0);
    send_beat(MODE_DFS, 0, 0);
    send_beat(MODE_BFS, 0, 0);
    // Edge extremes, self loop, endpoints out of range (0 and above NODES, all bits set).
    send_beat(MODE_ADD, 1, 64);
    send_beat(MODE_ADD, 64, 64);
    send_beat(MODE_ADD, 1, 2);
    send_beat(MODE_ADD, 2, 3);
    send_beat(MODE_ADD, 0, 5);
    send_beat(MODE_ADD, 5, 0);
    send_beat(MODE_ADD, 65, 3);
    send_beat(MODE_ADD, 3, 127);
    send_beat(MODE_ADD, 127, 127);
    send_beat(MODE_ADD, 42, 21);
    send_beat(MODE_BFS, 0, 0);
    send_beat(MODE_DFS, 127, 127);
    send_beat(MODE_REPORT, 85, 42);
    // Node count extremes: zero acts as one, above the node range acts as all.
    write_count(0);
    send_beat(MODE_DFS, 0, 0);
    send_beat(MODE_REPORT, 0, 0);
    write_count(127);
    send_beat(MODE_REPORT, 0, 0);
    write_count(1);
    send_beat(MODE_DFS, 0, 0);

    // Back-pressure: sink holds off while traversals queue behind.
    write_count(64);
    hold_long = 1'b1;
    send_beat(MODE_BFS, 0, 0);
    send_beat(MODE_REPORT, 0, 0);

    // Random phases: small and full-range graphs in turn, a few traversals each.
    for (int ph = 0; ph < 6; ph++) begin
      int hi;
      write_count(ph == 5 ? 64 : $urandom_range(1, 64));
      hi = (ph % 2) ? 12 : 64;
      if (ph == 5) calm = 1'b1;
      for (int k = 0; k < 16; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(mode_e'($urandom_range(0, 3)), $urandom_range(0, 127),
                    $urandom_range(0, 127));
        else
          send_edge_rand(hi);
      end
      send_beat(MODE_BFS, 0, 0);
      send_beat(MODE_DFS, 0, 0);
      send_beat(MODE_REPORT, 0, 0);
    end

    // Fill the store until edges are dropped (512 entries, 2 per edge).
    repeat (180) send_beat(MODE_ADD, $urandom_range(1, 64), $urandom_range(1, 64));
    send_beat(MODE_ADD, 7, 8);
    send_beat(MODE_BFS, 0, 0);
    send_beat(MODE_DFS, 0, 0);
    send_beat(MODE_REPORT, 0, 0);

    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
